>>> design/hlr_pkg.sv
// Package: shared types and constants for the HSL lightness ramp converter.
`timescale 1ns / 1ps

package hlr_pkg;

  localparam int MAX_STEPS_DEF     = 64;
  localparam int FRACTION_BITS_DEF = 12;

  localparam int HUE_W      = 9;
  localparam int SAT_W      = 13;
  localparam int CNT_W      = 7;
  localparam int CHAN_W     = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam int HUE_SECTOR = 60;
  localparam int HUE_TURN   = 360;
  localparam int MIN_STEPS  = 2;

  localparam int QUO_W      = 8;
  localparam int DIV_CNT_W  = $clog2(QUO_W);

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SCALE,
    ST_NUM,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic prod;
    logic scale;
    logic num;
    logic div;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic final_step;
    logic out_busy;
  } status_t;

endpackage

>>> design/hsl_lightness_ramp_to_rgb_top.sv
// Top level: HSL lightness ramp to RGB converter.
`timescale 1ns / 1ps

// Each accepted word (hue, saturation, step count n clamped to 2..MAX_STEPS)
// yields n RGB words with lightness falling from 1 to 0; tlast marks the
// darkest one. Channels are even-quantized and saturate at 255. Input is
// taken only while idle. Each color passes through the setup steps span
// product, chroma scale and numerator, then the three parallel bit-serial
// restoring dividers, and then an emit step that waits while the output
// register is held by tready.

module hsl_lightness_ramp_to_rgb_top #(
  parameter int MAX_STEPS     = hlr_pkg::MAX_STEPS_DEF,
  parameter int FRACTION_BITS = hlr_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [hlr_pkg::IN_DATA_W-1:0]  s_tdata,   // hue_degrees, saturation, step_count
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [hlr_pkg::OUT_DATA_W-1:0] m_tdata,   // red, green, blue
  output logic                           m_tlast
);

  hlr_pkg::cmd_t    cmd;
  hlr_pkg::status_t status;

  hlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hlr_datapath #(
    .MAX_STEPS     (MAX_STEPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> design/hlr_ctrl.sv
// Controller: sequences a load per word, then product, scale, numerator, divide and emit steps per color.
`timescale 1ns / 1ps

module hlr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  hlr_pkg::status_t status,
  output hlr_pkg::cmd_t    cmd
);

  hlr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hlr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      hlr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = hlr_pkg::ST_PROD;
        end
      end
      hlr_pkg::ST_PROD: begin
        cmd.prod   = 1'b1;
        state_next = hlr_pkg::ST_SCALE;
      end
      hlr_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = hlr_pkg::ST_NUM;
      end
      hlr_pkg::ST_NUM: begin
        cmd.num    = 1'b1;
        state_next = hlr_pkg::ST_DIV;
      end
      hlr_pkg::ST_DIV: begin
        cmd.div = 1'b1;
        if (status.div_last) begin
          state_next = hlr_pkg::ST_EMIT;
        end
      end
      hlr_pkg::ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = status.final_step ? hlr_pkg::ST_IDLE : hlr_pkg::ST_PROD;
        end
      end
      default: begin
        state_next = hlr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/hlr_datapath.sv
// Datapath: operand registers, chroma multipliers, three bit-serial dividers, output word.
`timescale 1ns / 1ps

module hlr_datapath #(
  parameter int MAX_STEPS     = hlr_pkg::MAX_STEPS_DEF,
  parameter int FRACTION_BITS = hlr_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  hlr_pkg::cmd_t                  cmd,
  output hlr_pkg::status_t               status,
  input  logic [hlr_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [hlr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast
);

  localparam int AW   = $clog2(MAX_STEPS);
  localparam int CW   = $clog2(MAX_STEPS + 1);
  localparam int SW   = FRACTION_BITS + 1;
  localparam int DW   = AW + FRACTION_BITS + 6;
  localparam int NW   = DW + 8;
  localparam int PW   = AW + SW;
  localparam int NCW  = (hlr_pkg::CNT_W > CW) ? hlr_pkg::CNT_W : CW;
  localparam int SCW  = (hlr_pkg::SAT_W > SW) ? hlr_pkg::SAT_W : SW;
  localparam int HW   = hlr_pkg::HUE_W;
  localparam int QW   = hlr_pkg::QUO_W;
  localparam int CHW  = hlr_pkg::CHAN_W;

  // operand registers
  hlr_pkg::sector_t sector;
  logic [5:0]       tri_w;
  logic [SW-1:0]    sat;
  logic [AW-1:0]    d;
  logic [AW-1:0]    a;
  logic [DW-1:0]    den;

  // per-color pipeline registers
  logic [PW-1:0]    prod;
  logic [DW-1:0]    cn;
  logic [DW-1:0]    xn;
  logic [DW-1:0]    mn;
  logic [NW-1:0]    rem [3];
  logic [QW-1:0]    quo [3];
  logic [NW-1:0]    dsh;
  logic [hlr_pkg::DIV_CNT_W-1:0] dcnt;

  logic [hlr_pkg::OUT_DATA_W-1:0] out_word;
  logic                           out_last;
  logic                           out_valid;

  // input decode
  logic [HW-1:0]                hue_in, hue_w;
  logic [hlr_pkg::SAT_W-1:0]    sat_in;
  logic [hlr_pkg::CNT_W-1:0]    cnt_in;
  logic [6:0]                   hp;
  logic [5:0]                   tri_next;
  hlr_pkg::sector_t             sector_next;
  logic [NCW-1:0]               n_ext, n_clamp;
  logic [AW-1:0]                d_next;
  logic [AW+5:0]                d60;
  logic [SCW-1:0]               sat_ext, one_ext;
  logic [SW-1:0]                sat_next;

  always_comb begin
    hue_in = s_tdata[HW-1:0];
    sat_in = s_tdata[HW+hlr_pkg::SAT_W-1:HW];
    cnt_in = s_tdata[HW+hlr_pkg::SAT_W+hlr_pkg::CNT_W-1:HW+hlr_pkg::SAT_W];

    hue_w = (hue_in >= HW'(hlr_pkg::HUE_TURN)) ? hue_in - HW'(hlr_pkg::HUE_TURN) : hue_in;

    priority if (hue_w < HW'(hlr_pkg::HUE_SECTOR))     sector_next = hlr_pkg::SEC_RY;
    else if (hue_w < HW'(2 * hlr_pkg::HUE_SECTOR))     sector_next = hlr_pkg::SEC_YG;
    else if (hue_w < HW'(3 * hlr_pkg::HUE_SECTOR))     sector_next = hlr_pkg::SEC_GC;
    else if (hue_w < HW'(4 * hlr_pkg::HUE_SECTOR))     sector_next = hlr_pkg::SEC_CB;
    else if (hue_w < HW'(5 * hlr_pkg::HUE_SECTOR))     sector_next = hlr_pkg::SEC_BM;
    else                                               sector_next = hlr_pkg::SEC_MR;

    // position within the 120 degree period, then triangular ramp 0..60..0
    priority if (hue_w < HW'(2 * hlr_pkg::HUE_SECTOR)) hp = hue_w[6:0];
    else if (hue_w < HW'(4 * hlr_pkg::HUE_SECTOR))     hp = 7'(hue_w - HW'(2 * hlr_pkg::HUE_SECTOR));
    else                                               hp = 7'(hue_w - HW'(4 * hlr_pkg::HUE_SECTOR));
    tri_next = (hp >= 7'(hlr_pkg::HUE_SECTOR)) ? 6'(7'(2 * hlr_pkg::HUE_SECTOR) - hp) : hp[5:0];

    n_ext = NCW'(cnt_in);
    priority if (n_ext < NCW'(hlr_pkg::MIN_STEPS)) n_clamp = NCW'(hlr_pkg::MIN_STEPS);
    else if (n_ext > NCW'(MAX_STEPS))              n_clamp = NCW'(MAX_STEPS);
    else                                           n_clamp = n_ext;
    d_next = AW'(n_clamp - NCW'(1));
    d60    = (AW+6)'(d_next) * (AW+6)'(hlr_pkg::HUE_SECTOR);

    sat_ext  = SCW'(sat_in);
    one_ext  = SCW'(1) << FRACTION_BITS;
    sat_next = SW'((sat_ext > one_ext) ? one_ext : sat_ext);
  end

  // product stage: span = (1 - |2l - 1|) scaled by d
  logic [AW:0]   twoa, dext, dist_l;
  logic [AW-1:0] span;

  always_comb begin
    twoa   = {a, 1'b0};
    dext   = (AW+1)'(d);
    dist_l = (twoa >= dext) ? twoa - dext : dext - twoa;
    span   = AW'(dext - dist_l);
  end

  // scale stage
  logic [PW+5:0] c_full, x_full;
  logic [AW+5:0] a60;
  logic [DW-1:0] ln, c_trunc;

  always_comb begin
    c_full  = (PW+6)'(prod) * (PW+6)'(hlr_pkg::HUE_SECTOR);
    x_full  = (PW+6)'(prod) * (PW+6)'(tri_w);
    a60     = (AW+6)'(a) * (AW+6)'(hlr_pkg::HUE_SECTOR);
    ln      = {a60, {FRACTION_BITS{1'b0}}};
    c_trunc = DW'(c_full);
  end

  // numerator stage: channel selection and 255*v + den
  logic [DW-1:0] vr, vg, vb;
  logic [NW-1:0] num_r, num_g, num_b;

  always_comb begin
    vr = mn;
    vg = mn;
    vb = mn;
    unique case (sector)
      hlr_pkg::SEC_RY: begin vr = cn + mn; vg = xn + mn; end
      hlr_pkg::SEC_YG: begin vr = xn + mn; vg = cn + mn; end
      hlr_pkg::SEC_GC: begin vg = cn + mn; vb = xn + mn; end
      hlr_pkg::SEC_CB: begin vg = xn + mn; vb = cn + mn; end
      hlr_pkg::SEC_BM: begin vr = xn + mn; vb = cn + mn; end
      default:         begin vr = cn + mn; vb = xn + mn; end
    endcase
    num_r = (NW'(vr) << 8) - NW'(vr) + NW'(den);
    num_g = (NW'(vg) << 8) - NW'(vg) + NW'(den);
    num_b = (NW'(vb) << 8) - NW'(vb) + NW'(den);
  end

  function automatic logic [CHW-1:0] even_chan(input logic [QW-1:0] q);
    even_chan = q[QW-1] ? {CHW{1'b1}} : {q[QW-2:0], 1'b0};
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sector <= sector_next;
      tri_w  <= tri_next;
      sat    <= sat_next;
      d      <= d_next;
      a      <= d_next;
      den    <= {d60, {FRACTION_BITS{1'b0}}};
    end
    if (cmd.prod) begin
      prod <= PW'(span) * PW'(sat);
    end
    if (cmd.scale) begin
      cn <= c_trunc;
      xn <= DW'(x_full);
      mn <= ln - (c_trunc >> 1);
    end
    if (cmd.num) begin
      rem[0] <= num_r;
      rem[1] <= num_g;
      rem[2] <= num_b;
      dsh    <= NW'(den) << 8;
      dcnt   <= '0;
    end
    if (cmd.div) begin
      for (int k = 0; k < 3; k++) begin
        if (rem[k] >= dsh) begin
          rem[k] <= rem[k] - dsh;
          quo[k] <= {quo[k][QW-2:0], 1'b1};
        end else begin
          quo[k] <= {quo[k][QW-2:0], 1'b0};
        end
      end
      dsh  <= dsh >> 1;
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.emit) begin
      out_word <= {even_chan(quo[2]), even_chan(quo[1]), even_chan(quo[0])};
      out_last <= (a == '0);
      if (a != '0) begin
        a <= a - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    status.div_last   = (dcnt == {hlr_pkg::DIV_CNT_W{1'b1}});
    status.final_step = (a == '0);
    status.out_busy   = out_valid && !m_tready;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_word;
  assign m_tlast  = out_last;

endmodule

>>> design/hlr_checker.sv
// Checker: port-level properties of the converter, bound to the top level.
`timescale 1ns / 1ps

module hlr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [hlr_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // one word in flight: input closes after acceptance
  a_in_close: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted back to back");

  // a result waiting while idle must be the end of a run
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("idle with a run unfinished");

  // channels are even or saturated
  a_even: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[0] || m_tdata[7:0] == 8'hFF) &&
                 (!m_tdata[8] || m_tdata[15:8] == 8'hFF) &&
                 (!m_tdata[16] || m_tdata[23:16] == 8'hFF))
    else $error("odd channel value");

endmodule

bind hsl_lightness_ramp_to_rgb_top hlr_checker u_checker (.*);

>>> sim/hsl_lightness_ramp_to_rgb_top_tb.sv
// Testbench: self-checking stream test of the HSL lightness ramp to RGB converter.
`timescale 1ns / 1ps

module hsl_lightness_ramp_to_rgb_top_tb;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int MAX_IDLE       = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_WORDS   = 232;
  localparam int MAX_PRINTS     = 20;
  localparam int CHAN_MAX       = 255;
  localparam int SAT_ONE        = 1 << hlr_pkg::FRACTION_BITS_DEF;

  typedef logic [hlr_pkg::HUE_W-1:0]  hue_t;
  typedef logic [hlr_pkg::SAT_W-1:0]  sat_t;
  typedef logic [hlr_pkg::CNT_W-1:0]  cnt_t;
  typedef logic [hlr_pkg::CHAN_W-1:0] chan_t;

  typedef struct {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last_step;
  } rgb_word_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [hlr_pkg::IN_DATA_W-1:0]  s_tdata;   // hue_degrees, saturation, step_count
  logic                           m_tvalid;
  logic                           m_tready;
  logic [hlr_pkg::OUT_DATA_W-1:0] m_tdata;   // red, green, blue
  logic                           m_tlast;

  rgb_word_t pending_colors[$];

  hue_t held_hue;
  sat_t held_sat;
  cnt_t run_len;
  cnt_t last_index;

  int  mismatches;
  int  words_sent;
  int  colors_checked;
  int  idle_cycles;
  bit  idle_on;
  bit  hold_req;
  bit  rst_done;

  hsl_lightness_ramp_to_rgb_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic chan_t quantize(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (CHAN_MAX * num + den) / (2 * den);
    return (2 * q > CHAN_MAX) ? chan_t'(CHAN_MAX) : chan_t'(2 * q);
  endfunction

  // Queue the colors of one ramp, darkest last.
  task automatic predict_ramp(input hue_t hue_in, input sat_t sat_in, input cnt_t cnt_in);
    longint unsigned  n, d, den, sat, hue, hp, tri_x, a, twoa, dist_l, span;
    longint unsigned  c_num, x_num, l_num, m_num, r, g, b;
    hlr_pkg::sector_t sec;
    rgb_word_t        w;
    n = cnt_in;
    if (n < hlr_pkg::MIN_STEPS) n = hlr_pkg::MIN_STEPS;
    if (n > hlr_pkg::MAX_STEPS_DEF) n = hlr_pkg::MAX_STEPS_DEF;
    sat = (sat_in > SAT_ONE) ? SAT_ONE : sat_in;
    held_hue = hue_in;
    held_sat = sat_t'(sat);
    run_len  = cnt_t'(n);
    hue   = hue_in % hlr_pkg::HUE_TURN;
    sec   = hlr_pkg::sector_t'(hue / hlr_pkg::HUE_SECTOR);
    hp    = hue % (2 * hlr_pkg::HUE_SECTOR);
    tri_x = (hp >= hlr_pkg::HUE_SECTOR) ? 2 * hlr_pkg::HUE_SECTOR - hp : hp;
    d     = n - 1;
    den   = d * SAT_ONE * hlr_pkg::HUE_SECTOR;
    for (longint unsigned i = 0; i < n; i++) begin
      a      = d - i;
      twoa   = 2 * a;
      dist_l = (twoa >= d) ? twoa - d : d - twoa;
      span   = d - dist_l;
      c_num  = span * sat * hlr_pkg::HUE_SECTOR;
      x_num  = span * sat * tri_x;
      l_num  = a * SAT_ONE * hlr_pkg::HUE_SECTOR;
      m_num  = l_num - c_num / 2;
      r = 0;
      g = 0;
      b = 0;
      case (sec)
        hlr_pkg::SEC_RY: begin r = c_num; g = x_num; end
        hlr_pkg::SEC_YG: begin r = x_num; g = c_num; end
        hlr_pkg::SEC_GC: begin g = c_num; b = x_num; end
        hlr_pkg::SEC_CB: begin g = x_num; b = c_num; end
        hlr_pkg::SEC_BM: begin r = x_num; b = c_num; end
        default: begin r = c_num; b = x_num; end
      endcase
      w.red       = quantize(r + m_num, den);
      w.green     = quantize(g + m_num, den);
      w.blue      = quantize(b + m_num, den);
      w.last_step = (i == d);
      pending_colors.push_back(w);
    end
    last_index = cnt_t'(d);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic send_word(input hue_t hue, input sat_t sat, input cnt_t cnt);
    int gap;
    gap = idle_on ? $urandom_range(MAX_IDLE) : 0;
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(hlr_pkg::IN_DATA_W - hlr_pkg::HUE_W - hlr_pkg::SAT_W - hlr_pkg::CNT_W){1'b0}},
                 cnt, sat, hue};
    do @(posedge clk); while (!s_tready);
    predict_ramp(hue, sat, cnt);
    words_sent++;
  endtask

  // Receiver: per-word stall, or one long hold when requested.
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst_done);
    forever begin
      if (hold_req) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(MAX_IDLE) : 0;
      if (stall > 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    rgb_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_colors.size() == 0) begin
        report_mismatch("unexpected color, rgb", m_tdata, 0);
      end else begin
        w = pending_colors.pop_front();
        colors_checked++;
        if (m_tdata[hlr_pkg::CHAN_W-1:0] !== w.red)
          report_mismatch("red", m_tdata[hlr_pkg::CHAN_W-1:0], w.red);
        if (m_tdata[2*hlr_pkg::CHAN_W-1:hlr_pkg::CHAN_W] !== w.green)
          report_mismatch("green", m_tdata[2*hlr_pkg::CHAN_W-1:hlr_pkg::CHAN_W], w.green);
        if (m_tdata[3*hlr_pkg::CHAN_W-1:2*hlr_pkg::CHAN_W] !== w.blue)
          report_mismatch("blue", m_tdata[3*hlr_pkg::CHAN_W-1:2*hlr_pkg::CHAN_W], w.blue);
        if (m_tlast !== w.last_step)
          report_mismatch("tlast", m_tlast, w.last_step);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_count_clamp;
    cnt_t counts[7] = '{0, 1, 2, 3, 64, 65, 127};
    foreach (counts[k]) send_word(hue_t'(0), sat_t'(SAT_ONE), counts[k]);
  endtask

  task automatic test_hue_sectors;
    hue_t hues[11] = '{0, 59, 60, 119, 120, 180, 240, 300, 359, 360, 511};
    foreach (hues[k]) send_word(hues[k], sat_t'(SAT_ONE), cnt_t'(5));
  endtask

  task automatic test_saturation;
    sat_t sats[6] = '{0, 1, sat_t'(SAT_ONE - 1), sat_t'(SAT_ONE), sat_t'(SAT_ONE + 1), 13'h1FFF};
    foreach (sats[k]) send_word(hue_t'(200), sats[k], cnt_t'(7));
  endtask

  task automatic test_output_backpressure;
    hold_req = 1'b1;
    repeat (4) send_word(hue_t'($urandom_range(511)), sat_t'($urandom_range(SAT_ONE)),
                         cnt_t'($urandom_range(8, 2)));
  endtask

  task automatic test_random;
    sat_t sat;
    cnt_t cnt;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 50 == 0) idle_on = ($urandom_range(3) != 0);
      sat = sat_t'(($urandom_range(9) < 7) ? $urandom_range(SAT_ONE) : $urandom_range(13'h1FFF));
      cnt = cnt_t'(($urandom_range(3) != 0) ? $urandom_range(16) : $urandom_range(127));
      send_word(hue_t'($urandom_range(511)), sat, cnt);
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    idle_on  = 1'b0;
    hold_req = 1'b0;
    rst_done = 1'b0;
    mismatches     = 0;
    words_sent     = 0;
    colors_checked = 0;
    idle_cycles    = 0;
    held_hue   = '0;
    held_sat   = '0;
    run_len    = '0;
    last_index = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    rst_done = 1'b1;

    test_count_clamp();
    idle_on = 1'b1;
    test_hue_sectors();
    test_saturation();
    test_output_backpressure();
    test_random();

    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (clamped counts, all hue sectors, saturation extremes,", words_sent);
    $display("long output hold) and checked %0d colors", colors_checked);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
design/hlr_pkg.sv
design/hlr_ctrl.sv
design/hlr_datapath.sv
design/hsl_lightness_ramp_to_rgb_top.sv
design/hlr_checker.sv
sim/hsl_lightness_ramp_to_rgb_top_tb.sv
